>>> rtl/core/rva_pkg.sv
// Shared constants, types and tables for the axis rotation pipeline.
// Used by every module of rotate_vector_about_axis; depends on nothing.
package rva_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int ROTATION_STAGES = 18;
    localparam int ANGLE_WIDTH     = 24;
    localparam int AXIS_WIDTH      = 2;
    localparam int CS_FRAC         = 30;

    typedef enum logic [AXIS_WIDTH-1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    // stream packing
    localparam int S_TDATA_W = ((3 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;

    // angle wrap: full turn and half turn in input angle units
    localparam int FULL_ANG    = 360 << ANGLE_FRAC_BITS;
    localparam int HALF_ANG    = 180 << ANGLE_FRAC_BITS;
    localparam int MAG_W       = ANGLE_WIDTH;
    localparam int RECIP_SHIFT = 37;
    localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SHIFT) / FULL_ANG;
    localparam int RECIP_W     = $clog2(RECIP_FULL + 1);
    localparam int REM_W       = $clog2(2 * FULL_ANG);
    localparam int FOLD_W      = $clog2(HALF_ANG + 1);

    // a full turn is Sector << (ANGLE_FRAC_BITS + 3)
    localparam int SECTOR        = 45;
    localparam int SECTOR_SHIFT  = 24;
    localparam int RECIP_SECTOR  = (1 << SECTOR_SHIFT) / SECTOR;
    localparam int RS_W          = $clog2(RECIP_SECTOR + 1);
    localparam int SREM_W        = 7;
    localparam int SLUT_IDX_W    = 6;
    localparam int TURN_LUT_DEPTH = 1 << SLUT_IDX_W;
    localparam int TURN_SHIFT    = 29 - ANGLE_FRAC_BITS;
    localparam int TURN_BIAS     = SECTOR / 2;
    localparam int TURN_W        = 32;

    typedef logic [MAG_W-1:0]            mag_t;
    typedef logic [MAG_W+RECIP_W-1:0]    qprod_t;
    typedef logic [REM_W-1:0]            rem_t;
    typedef logic [FOLD_W-1:0]           fold_t;
    typedef logic [FOLD_W+RS_W-1:0]      fprod_t;
    typedef logic [SREM_W-1:0]           srem_t;
    typedef logic [TURN_W-1:0]           turn_t;

    localparam mag_t  FULL_MAG     = mag_t'(FULL_ANG);
    localparam rem_t  FULL_REM     = rem_t'(FULL_ANG);
    localparam rem_t  HALF_REM     = rem_t'(HALF_ANG);
    localparam fold_t SECTOR_FOLD  = fold_t'(SECTOR);
    localparam srem_t SECTOR_SREM  = srem_t'(SECTOR);
    localparam turn_t QUARTER_TURN = turn_t'(64'd1 << 30);
    localparam turn_t HALF_TURN    = turn_t'(64'd1 << 31);

    typedef logic [TURN_W-1:0] turn_lut_t [TURN_LUT_DEPTH];

    function automatic turn_lut_t build_turn_lut();
        turn_lut_t lut;
        for (int i = 0; i < TURN_LUT_DEPTH; i++) begin
            if (i < SECTOR) begin
                lut[i] = turn_t'(((64'(i) << TURN_SHIFT) + 64'(TURN_BIAS)) / SECTOR);
            end else begin
                lut[i] = '0;
            end
        end
        return lut;
    endfunction

    localparam turn_lut_t TURN_LUT = build_turn_lut();

    // CORDIC
    localparam int XY_W        = 34;
    localparam int TH_W        = 33;
    localparam int ATAN_DEPTH  = 31;
    localparam int STAGE_IDX_W = $clog2(ATAN_DEPTH);

    typedef logic signed [XY_W-1:0]        xy_t;
    typedef logic signed [TH_W-1:0]        theta_t;
    typedef logic [STAGE_IDX_W-1:0]        stage_idx_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam xy_t CORDIC_START = xy_t'(652032874);

    localparam logic [31:0] ATAN_TURN [ATAN_DEPTH] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001
    };

    // products and rounding
    localparam int PROD_W    = COORD_WIDTH + XY_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int SHIFTED_W = SUM_W - CS_FRAC;

    typedef logic signed [PROD_W-1:0]    prod_t;
    typedef logic signed [SUM_W-1:0]     sum_t;
    typedef logic signed [SHIFTED_W-1:0] shifted_t;

    typedef struct packed {
        coord_t vec_x;
        coord_t vec_y;
        coord_t vec_z;
        axis_t  axis_code;
    } vec_item_t;

    typedef struct packed {
        logic      valid;
        vec_item_t item;
        logic      flip;
        xy_t       x;
        xy_t       y;
        theta_t    theta;
    } cordic_lane_t;

    typedef struct packed {
        coord_t rot_x;
        coord_t rot_y;
        coord_t rot_z;
        logic   saturated;
    } rot_result_t;

endpackage

>>> rtl/core/rva_angle_prep.sv
// Angle front end: wrap to a half turn, convert to binary angle, fold quadrant.
// Eight register stages; feeds the first CORDIC cell. Depends on rva_pkg.
module rva_angle_prep (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  rva_pkg::vec_item_t                in_item,
    input  logic signed [rva_pkg::ANGLE_WIDTH-1:0] in_angle,
    output rva_pkg::cordic_lane_t             lane_out
);

    logic [7:0]         valid_reg;
    logic [6:0]         sgn_reg;
    rva_pkg::vec_item_t item_reg [8];

    rva_pkg::mag_t   mag0_reg, mag0_next;
    rva_pkg::mag_t   mag1_reg;
    rva_pkg::mag_t   quot1_reg, quot1_next;
    rva_pkg::rem_t   rem2_reg, rem2_next;
    rva_pkg::fold_t  fold3_reg, fold3_next;
    rva_pkg::fold_t  fold4_reg;
    rva_pkg::fold_t  sq4_reg, sq4_next;
    rva_pkg::fold_t  sq5_reg;
    rva_pkg::srem_t  srem5_reg, srem5_next;
    rva_pkg::turn_t  turn6_reg, turn6_next;
    rva_pkg::theta_t theta7_reg, theta7_next;
    logic            flip7_reg, flip7_next;

    rva_pkg::qprod_t qprod;
    rva_pkg::fprod_t fprod;
    rva_pkg::rem_t   rem_red;
    logic            wrap;
    logic            over;
    rva_pkg::srem_t  srem_fix;
    rva_pkg::fold_t  sq_fix;
    logic            past;
    rva_pkg::turn_t  tmag;

    always_comb begin
        mag0_next  = in_angle[rva_pkg::ANGLE_WIDTH-1] ? rva_pkg::mag_t'(-in_angle)
                                                      : rva_pkg::mag_t'(in_angle);

        qprod      = rva_pkg::qprod_t'(mag0_reg) * rva_pkg::qprod_t'(rva_pkg::RECIP_FULL);
        quot1_next = rva_pkg::mag_t'(qprod >> rva_pkg::RECIP_SHIFT);

        rem2_next  = rva_pkg::rem_t'(mag1_reg - quot1_reg * rva_pkg::FULL_MAG);

        rem_red    = (rem2_reg >= rva_pkg::FULL_REM) ? rem2_reg - rva_pkg::FULL_REM : rem2_reg;
        wrap       = rem_red > rva_pkg::HALF_REM;
        fold3_next = wrap ? rva_pkg::fold_t'(rva_pkg::FULL_REM - rem_red)
                          : rva_pkg::fold_t'(rem_red);

        fprod      = rva_pkg::fprod_t'(fold3_reg) * rva_pkg::fprod_t'(rva_pkg::RECIP_SECTOR);
        sq4_next   = rva_pkg::fold_t'(fprod >> rva_pkg::SECTOR_SHIFT);

        srem5_next = rva_pkg::srem_t'(fold4_reg - sq4_reg * rva_pkg::SECTOR_FOLD);

        over       = srem5_reg >= rva_pkg::SECTOR_SREM;
        srem_fix   = over ? srem5_reg - rva_pkg::SECTOR_SREM : srem5_reg;
        sq_fix     = over ? sq5_reg + rva_pkg::fold_t'(1) : sq5_reg;
        turn6_next = (rva_pkg::turn_t'(sq_fix) << rva_pkg::TURN_SHIFT)
                   + rva_pkg::TURN_LUT[srem_fix[rva_pkg::SLUT_IDX_W-1:0]];

        past        = turn6_reg > rva_pkg::QUARTER_TURN;
        tmag        = past ? rva_pkg::HALF_TURN - turn6_reg : turn6_reg;
        theta7_next = (sgn_reg[6] ^ past) ? -rva_pkg::theta_t'(tmag) : rva_pkg::theta_t'(tmag);
        flip7_next  = past;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= in_item;
            for (int k = 1; k < 8; k++) begin
                item_reg[k] <= item_reg[k-1];
            end
            sgn_reg    <= {sgn_reg[5:3], sgn_reg[2] ^ wrap, sgn_reg[1:0],
                           in_angle[rva_pkg::ANGLE_WIDTH-1]};
            mag0_reg   <= mag0_next;
            mag1_reg   <= mag0_reg;
            quot1_reg  <= quot1_next;
            rem2_reg   <= rem2_next;
            fold3_reg  <= fold3_next;
            fold4_reg  <= fold3_reg;
            sq4_reg    <= sq4_next;
            sq5_reg    <= sq4_reg;
            srem5_reg  <= srem5_next;
            turn6_reg  <= turn6_next;
            theta7_reg <= theta7_next;
            flip7_reg  <= flip7_next;
        end
    end

    always_comb begin
        lane_out.valid = valid_reg[7];
        lane_out.item  = item_reg[7];
        lane_out.flip  = flip7_reg;
        lane_out.x     = rva_pkg::CORDIC_START;
        lane_out.y     = '0;
        lane_out.theta = theta7_reg;
    end

endmodule

>>> rtl/core/rva_cordic_cell.sv
// One CORDIC rotation cell: a shift-add micro-rotation and one atan step.
// Cells chain into the sine/cosine pipeline. Depends on rva_pkg.
module rva_cordic_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  rva_pkg::stage_idx_t   stage_idx,
    input  rva_pkg::cordic_lane_t lane_in,
    output rva_pkg::cordic_lane_t lane_out
);

    rva_pkg::cordic_lane_t lane_reg, lane_next;
    rva_pkg::xy_t          x_in, y_in, dx, dy;
    rva_pkg::theta_t       step;

    always_comb begin
        x_in      = lane_in.x;
        y_in      = lane_in.y;
        dx        = y_in >>> stage_idx;
        dy        = x_in >>> stage_idx;
        step      = rva_pkg::theta_t'(rva_pkg::ATAN_TURN[stage_idx]);
        lane_next = lane_in;
        if (!lane_in.theta[rva_pkg::TH_W-1]) begin
            lane_next.x     = x_in - dx;
            lane_next.y     = y_in + dy;
            lane_next.theta = lane_in.theta - step;
        end else begin
            lane_next.x     = x_in + dx;
            lane_next.y     = y_in - dy;
            lane_next.theta = lane_in.theta + step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg.valid <= 1'b0;
        end else if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

>>> rtl/core/rva_rotate_mac.sv
// Rotation products: select the plane, multiply by cos/sin, round, saturate.
// Three register stages, the last one is the output register. Depends on rva_pkg.
module rva_rotate_mac (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  rva_pkg::cordic_lane_t lane_in,
    output logic                  out_valid,
    output rva_pkg::rot_result_t  out_result
);

    logic [1:0]           valid_reg;
    logic                 out_valid_reg;
    rva_pkg::vec_item_t   item_reg [2];
    rva_pkg::coord_t      a_reg, a_next, b_reg, b_next;
    rva_pkg::xy_t         c_reg, c_next, s_reg, s_next;
    rva_pkg::prod_t       ac_reg, bs_reg, as_reg, bc_reg;
    rva_pkg::rot_result_t res_reg, res_next;

    rva_pkg::sum_t        na_sum, nb_sum;
    logic [rva_pkg::COORD_WIDTH:0] na_cl, nb_cl;

    localparam rva_pkg::sum_t ROUND_HALF = rva_pkg::sum_t'(1) << (rva_pkg::CS_FRAC - 1);

    function automatic logic [rva_pkg::COORD_WIDTH:0] clamp_coord(input rva_pkg::sum_t v);
        rva_pkg::shifted_t sv;
        logic              hi_ones, hi_zeros;
        sv       = rva_pkg::shifted_t'(v >>> rva_pkg::CS_FRAC);
        hi_ones  = &sv[rva_pkg::SHIFTED_W-1:rva_pkg::COORD_WIDTH-1];
        hi_zeros = ~|sv[rva_pkg::SHIFTED_W-1:rva_pkg::COORD_WIDTH-1];
        if (hi_ones || hi_zeros) begin
            return {1'b0, sv[rva_pkg::COORD_WIDTH-1:0]};
        end else if (sv[rva_pkg::SHIFTED_W-1]) begin
            return {1'b1, 1'b1, {(rva_pkg::COORD_WIDTH-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(rva_pkg::COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    always_comb begin
        c_next = lane_in.flip ? -lane_in.x : lane_in.x;
        s_next = lane_in.flip ? -lane_in.y : lane_in.y;
        case (lane_in.item.axis_code)
            rva_pkg::AXIS_X: begin
                a_next = lane_in.item.vec_y;
                b_next = lane_in.item.vec_z;
            end
            rva_pkg::AXIS_Y: begin
                a_next = lane_in.item.vec_z;
                b_next = lane_in.item.vec_x;
            end
            default: begin
                a_next = lane_in.item.vec_x;
                b_next = lane_in.item.vec_y;
            end
        endcase
    end

    always_comb begin
        na_sum = rva_pkg::sum_t'(ac_reg) - rva_pkg::sum_t'(bs_reg) + ROUND_HALF;
        nb_sum = rva_pkg::sum_t'(as_reg) + rva_pkg::sum_t'(bc_reg) + ROUND_HALF;
        na_cl  = clamp_coord(na_sum);
        nb_cl  = clamp_coord(nb_sum);
        res_next.rot_x     = item_reg[1].vec_x;
        res_next.rot_y     = item_reg[1].vec_y;
        res_next.rot_z     = item_reg[1].vec_z;
        res_next.saturated = na_cl[rva_pkg::COORD_WIDTH] | nb_cl[rva_pkg::COORD_WIDTH];
        case (item_reg[1].axis_code)
            rva_pkg::AXIS_X: begin
                res_next.rot_y = na_cl[rva_pkg::COORD_WIDTH-1:0];
                res_next.rot_z = nb_cl[rva_pkg::COORD_WIDTH-1:0];
            end
            rva_pkg::AXIS_Y: begin
                res_next.rot_z = na_cl[rva_pkg::COORD_WIDTH-1:0];
                res_next.rot_x = nb_cl[rva_pkg::COORD_WIDTH-1:0];
            end
            rva_pkg::AXIS_Z: begin
                res_next.rot_x = na_cl[rva_pkg::COORD_WIDTH-1:0];
                res_next.rot_y = nb_cl[rva_pkg::COORD_WIDTH-1:0];
            end
            default: begin
                res_next.saturated = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg     <= {valid_reg[0], lane_in.valid};
            out_valid_reg <= valid_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= lane_in.item;
            item_reg[1] <= item_reg[0];
            a_reg       <= a_next;
            b_reg       <= b_next;
            c_reg       <= c_next;
            s_reg       <= s_next;
            ac_reg      <= rva_pkg::prod_t'(a_reg) * rva_pkg::prod_t'(c_reg);
            bs_reg      <= rva_pkg::prod_t'(b_reg) * rva_pkg::prod_t'(s_reg);
            as_reg      <= rva_pkg::prod_t'(a_reg) * rva_pkg::prod_t'(s_reg);
            bc_reg      <= rva_pkg::prod_t'(b_reg) * rva_pkg::prod_t'(c_reg);
            res_reg     <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;

endmodule

>>> rtl/core/rotate_vector_about_axis.sv
// Rotation of a Q16.16 vector about X, Y or Z by an angle in 1/64 degree units.
// Pipeline: 8 angle stages, 18 CORDIC cells, 3 product/round/saturate stages.
// Throughput: one transfer per cycle; the whole pipeline holds while m_tvalid is high
// and m_tready is low.
// Reset: synchronous, active-low aresetn clears all valid flags; no clearing pass.
module rotate_vector_about_axis (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // vec_x, vec_y, vec_z, angle_deg
    input  logic [rva_pkg::S_TDATA_W-1:0]     s_tdata,
    // axis_code
    input  logic [rva_pkg::AXIS_WIDTH-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // rot_x, rot_y, rot_z
    output logic [rva_pkg::M_TDATA_W-1:0]     m_tdata,
    // saturated
    output logic [0:0]                        m_tuser
);

    logic                  en;
    rva_pkg::vec_item_t    in_item;
    rva_pkg::rot_result_t  result;
    rva_pkg::cordic_lane_t lane [rva_pkg::ROTATION_STAGES+1];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb begin
        in_item.vec_x     = s_tdata[rva_pkg::COORD_WIDTH-1:0];
        in_item.vec_y     = s_tdata[2*rva_pkg::COORD_WIDTH-1:rva_pkg::COORD_WIDTH];
        in_item.vec_z     = s_tdata[3*rva_pkg::COORD_WIDTH-1:2*rva_pkg::COORD_WIDTH];
        in_item.axis_code = rva_pkg::axis_t'(s_tuser);
    end

    rva_angle_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_item  (in_item),
        .in_angle (s_tdata[3*rva_pkg::COORD_WIDTH+rva_pkg::ANGLE_WIDTH-1:
                           3*rva_pkg::COORD_WIDTH]),
        .lane_out (lane[0])
    );

    for (genvar i = 0; i < rva_pkg::ROTATION_STAGES; i++) begin : g_cell
        rva_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .stage_idx (rva_pkg::stage_idx_t'(i)),
            .lane_in   (lane[i]),
            .lane_out  (lane[i+1])
        );
    end

    rva_rotate_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .lane_in    (lane[rva_pkg::ROTATION_STAGES]),
        .out_valid  (m_tvalid),
        .out_result (result)
    );

    always_comb begin
        m_tdata = '0;
        m_tdata[rva_pkg::COORD_WIDTH-1:0]                        = result.rot_x;
        m_tdata[2*rva_pkg::COORD_WIDTH-1:rva_pkg::COORD_WIDTH]   = result.rot_y;
        m_tdata[3*rva_pkg::COORD_WIDTH-1:2*rva_pkg::COORD_WIDTH] = result.rot_z;
        m_tuser[0] = result.saturated;
    end

endmodule

>>> rtl/core/rva_checker.sv
// Port-level checks for rotate_vector_about_axis, attached by bind.
// Depends on rva_pkg and on the top level's port list.
module rva_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [rva_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [rva_pkg::AXIS_WIDTH-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rva_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);

    localparam logic [rva_pkg::COORD_WIDTH-1:0] CMAX = {1'b0, {(rva_pkg::COORD_WIDTH-1){1'b1}}};
    localparam logic [rva_pkg::COORD_WIDTH-1:0] CMIN = {1'b1, {(rva_pkg::COORD_WIDTH-1){1'b0}}};

    logic [rva_pkg::COORD_WIDTH-1:0] ox, oy, oz;
    logic                            at_limit;

    assign ox = m_tdata[rva_pkg::COORD_WIDTH-1:0];
    assign oy = m_tdata[2*rva_pkg::COORD_WIDTH-1:rva_pkg::COORD_WIDTH];
    assign oz = m_tdata[3*rva_pkg::COORD_WIDTH-1:2*rva_pkg::COORD_WIDTH];
    assign at_limit = ox == CMAX || ox == CMIN || oy == CMAX || oy == CMIN
                   || oz == CMAX || oz == CMIN;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> at_limit)
        else $error("saturation flag without clamped component");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transfer changed while stalled");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tvalid && !m_tvalid && $past(!m_tvalid) |-> s_tready)
        else $error("input not ready while idle");

endmodule

bind rotate_vector_about_axis rva_checker u_rva_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
